// File: rtl/core/calendar_clock_tick_update_defines.svh
// Assertion macros for the calendar clock tick update block.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef CALENDAR_CLOCK_TICK_UPDATE_DEFINES_SVH
`define CALENDAR_CLOCK_TICK_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define RTCC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define RTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTCC_ASSERT(lbl, cond, msg)
`define RTCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/rtcc_pkg.sv
// Package for the calendar clock tick update block: payload types and constants.
// No dependencies; used by every module of the block.
`default_nettype none

package rtcc_pkg;

    localparam int ACC_W = 17;
    localparam int TOTAL_W = 32;
    localparam int TICK_W = 16;

    localparam logic [ACC_W-1:0] TICKS_PER_HALF = ACC_W'(32 * 500);

    localparam logic [6:0] LAST_HALF_SECOND = 7'((60 * 2) - 1);
    localparam logic [5:0] LAST_MINUTE      = 6'd59;
    localparam logic [4:0] LAST_HOUR        = 5'd23;
    localparam logic [2:0] LAST_WEEKDAY     = 3'd6;
    localparam logic [4:0] LAST_DATE        = 5'd30;
    localparam logic [4:0] LAST_DATE_SHORT  = 5'd29;
    localparam logic [4:0] LAST_DATE_FEB    = 5'd27;
    localparam logic [3:0] LAST_MONTH       = 4'd11;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_APR = 4'd3;
    localparam logic [3:0] MONTH_JUN = 4'd5;
    localparam logic [3:0] MONTH_SEP = 4'd8;
    localparam logic [3:0] MONTH_NOV = 4'd10;

    localparam logic REQ_ADVANCE = 1'b0;
    localparam logic REQ_LOAD    = 1'b1;

    typedef struct packed {
        logic [6:0] half_seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [2:0] weekday;
        logic [4:0] date;
        logic [3:0] month;
    } cal_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] time_passed;
        logic [6:0]  load_half_seconds;
        logic [5:0]  load_minutes;
        logic [4:0]  load_hours;
        logic [2:0]  load_weekday;
        logic [4:0]  load_date;
        logic [3:0]  load_month;
    } request_t;

    typedef struct packed {
        logic [31:0] raw_ticks;
        logic [13:0] sub_half_second;
        logic [6:0]  half_seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [2:0]  weekday;
        logic [4:0]  date;
        logic [3:0]  month;
    } result_t;

    // Last zero-based date of a month, no leap years.
    function automatic logic [4:0] last_date_of(input logic [3:0] month);
        logic [4:0] last;
        last = LAST_DATE;
        if (month == MONTH_FEB)
            last = LAST_DATE_FEB;
        else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV)
            last = LAST_DATE_SHORT;
        return last;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rtcc_chan_if.sv
// Valid/ready channel interface carrying one payload struct per transfer.
// Payload type is set by the instantiating level; no other dependencies.
`default_nettype none

interface rtcc_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rtcc_acc_alu.sv
// Shared accumulator adder: adds a tick count or takes off one half-second.
// Depends on rtcc_pkg.
`default_nettype none

module rtcc_acc_alu
    import rtcc_pkg::*;
(
    input  wire logic [ACC_W-1:0]  acc,
    input  wire logic [TICK_W-1:0] addend,
    input  wire logic              sub,
    output logic [ACC_W-1:0]       sum,
    output logic                   ge
);

    localparam logic [ACC_W-1:0] NegHalf = ACC_W'((1 << ACC_W) - (32 * 500));

    logic [ACC_W-1:0] operand;

    // Pick the operand: the tick count, or minus one half-second in two's complement
    assign operand = sub ? NegHalf : {{(ACC_W-TICK_W){1'b0}}, addend};
    assign sum     = acc + operand;

    // Flag a pending half-second boundary
    assign ge = (acc >= TICKS_PER_HALF);

endmodule

`default_nettype wire

// File: rtl/core/rtcc_cal_step.sv
// Calendar carry chain: advances the calendar by one half-second.
// Depends on rtcc_pkg.
`default_nettype none

module rtcc_cal_step
    import rtcc_pkg::*;
(
    input  wire cal_t cur,
    output cal_t      nxt
);

    always_comb
    begin
        nxt = cur;
        // Carry through half-seconds, minutes and hours
        if (cur.half_seconds < LAST_HALF_SECOND)
        begin
            nxt.half_seconds = cur.half_seconds + 7'd1;
        end
        else
        begin
            nxt.half_seconds = '0;
            if (cur.minutes < LAST_MINUTE)
            begin
                nxt.minutes = cur.minutes + 6'd1;
            end
            else
            begin
                nxt.minutes = '0;
                if (cur.hours < LAST_HOUR)
                begin
                    nxt.hours = cur.hours + 5'd1;
                end
                else
                begin
                    // Roll the day: weekday, date and month
                    nxt.hours   = '0;
                    nxt.weekday = (cur.weekday >= LAST_WEEKDAY) ? 3'd0 : cur.weekday + 3'd1;
                    if (cur.date >= last_date_of(cur.month))
                    begin
                        nxt.date  = '0;
                        nxt.month = (cur.month >= LAST_MONTH) ? 4'd0 : cur.month + 4'd1;
                    end
                    else
                    begin
                        nxt.date = cur.date + 5'd1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/calendar_clock_tick_update.sv
// Real-time clock calendar. An advance request is taken in the idle state, where the tick
// count is added to the raw total and the sub-half-second accumulator; the shared
// accumulator adder then takes off one half-second per cycle, stepping the calendar
// each time, until the accumulator is below 16000 (at most five steps for a 16-bit
// count), and the emit state then copies the state into the result register once that
// register is free or being taken. A load clamps each field to its range, leaves the
// tick counters alone and goes straight to the emit state.
// The result register holds one finished result while the next request is worked.
// Depends on rtcc_pkg, rtcc_chan_if, rtcc_acc_alu, rtcc_cal_step and the defines header.
`default_nettype none
`include "calendar_clock_tick_update_defines.svh"

module calendar_clock_tick_update
    import rtcc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rtcc_chan_if.sink   request,
    rtcc_chan_if.source status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_STEP = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    cal_t                 cal_reg, cal_next;
    result_t              result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;

    logic [ACC_W-1:0]     alu_sum;
    logic                 alu_ge;
    logic                 alu_sub;
    cal_t                 cal_stepped;
    cal_t                 cal_loaded;
    request_t             req;
    logic                 take;

    assign req  = request.data;
    assign take = request.valid && request.ready;

    assign request.ready = (state_reg == S_IDLE);
    assign status.valid  = result_valid_reg;
    assign status.data   = result_reg;

    // Shared accumulator unit and one-step calendar carry
    assign alu_sub = (state_reg == S_STEP);

    rtcc_acc_alu u_acc_alu (
        .acc    (acc_reg),
        .addend (req.time_passed),
        .sub    (alu_sub),
        .sum    (alu_sum),
        .ge     (alu_ge)
    );

    rtcc_cal_step u_cal_step (
        .cur (cal_reg),
        .nxt (cal_stepped)
    );

    // Clamp loaded fields to their ranges
    always_comb
    begin
        cal_loaded.half_seconds = (req.load_half_seconds > LAST_HALF_SECOND) ?
                                  LAST_HALF_SECOND : req.load_half_seconds;
        cal_loaded.minutes = (req.load_minutes > LAST_MINUTE) ? LAST_MINUTE : req.load_minutes;
        cal_loaded.hours   = (req.load_hours > LAST_HOUR) ? LAST_HOUR : req.load_hours;
        cal_loaded.weekday = (req.load_weekday > LAST_WEEKDAY) ? LAST_WEEKDAY
                                                               : req.load_weekday;
        cal_loaded.date    = (req.load_date > LAST_DATE) ? LAST_DATE : req.load_date;
        cal_loaded.month   = (req.load_month > LAST_MONTH) ? LAST_MONTH : req.load_month;
    end

    // Sequencer: take a request, step half-seconds, hand the state to the result register
    always_comb
    begin
        state_next        = state_reg;
        total_next        = total_reg;
        acc_next          = acc_reg;
        cal_next          = cal_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        // Drop the held result once the sink takes it
        if (status.ready)
            result_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        cal_next   = cal_loaded;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        total_next = total_reg + {{(TOTAL_W-TICK_W){1'b0}}, req.time_passed};
                        acc_next   = alu_sum;
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (alu_ge)
                begin
                    acc_next = alu_sum;
                    cal_next = cal_stepped;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || status.ready)
                begin
                    result_next.raw_ticks       = total_reg;
                    result_next.sub_half_second = acc_reg[13:0];
                    result_next.half_seconds    = cal_reg.half_seconds;
                    result_next.minutes         = cal_reg.minutes;
                    result_next.hours           = cal_reg.hours;
                    result_next.weekday         = cal_reg.weekday;
                    result_next.date            = cal_reg.date;
                    result_next.month           = cal_reg.month;
                    result_valid_next           = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and clock state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            total_reg        <= '0;
            acc_reg          <= '0;
            cal_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            total_reg        <= total_next;
            acc_reg          <= acc_next;
            cal_reg          <= cal_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    `RTCC_ASSERT(a_acc_settled, (state_reg != S_IDLE) || (acc_reg < TICKS_PER_HALF), "accumulator not settled while idle")
    `RTCC_ASSERT_NEXT(a_step_exit, (state_reg == S_STEP) && !alu_ge, state_reg == S_EMIT, "step loop did not exit")
    `RTCC_ASSERT_NEXT(a_result_source, !result_valid_reg && status.valid == 1'b0 && state_reg != S_EMIT, !result_valid_reg, "result appeared without emit")
    `RTCC_ASSERT(a_cal_range, (cal_reg.half_seconds <= LAST_HALF_SECOND) && (cal_reg.minutes <= LAST_MINUTE) && (cal_reg.hours <= LAST_HOUR) && (cal_reg.weekday <= LAST_WEEKDAY) && (cal_reg.date <= LAST_DATE) && (cal_reg.month <= LAST_MONTH), "calendar field out of range")

endmodule

`default_nettype wire

// File: dv/calendar_clock_tick_update_test.sv
// Testbench for the calendar clock tick update block: directed corner cases, then random
// advances and loads through randomly idling valid/ready channels, checked against a predictor.
// Depends on rtcc_pkg, rtcc_chan_if and calendar_clock_tick_update.
`default_nettype none

module calendar_clock_tick_update_test;
    import rtcc_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        request_t req;
        int       gap;
        bit       drain;
    } pending_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic     req_valid = 1'b0;
    request_t req_data = '0;
    logic     res_ready = 1'b0;

    rtcc_chan_if #(.payload_t(request_t)) request_ch ();
    rtcc_chan_if #(.payload_t(result_t))  status_ch ();

    assign request_ch.valid = req_valid;
    assign request_ch.data  = req_data;
    assign status_ch.ready  = res_ready;

    calendar_clock_tick_update i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_ch),
        .status (status_ch)
    );

    always #4 clk = ~clk;

    // Predicted clock state
    logic [31:0] model_total = '0;
    logic [16:0] model_acc = '0;
    cal_t        model_cal = '0;

    pending_item_t pending_q[$];
    result_t       clock_state_q[$];

    int issued_count = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int advance_count = 0;
    int load_count = 0;
    int half_step_count = 0;
    int day_roll_count = 0;

    // Apply one request to the predicted state and return the status it leads to.
    function automatic result_t next_clock_state(input request_t rq);
        result_t    r;
        logic [4:0] month_last;
        if (rq.req_type == REQ_ADVANCE) begin
            advance_count++;
            model_total = model_total + 32'(rq.time_passed);
            model_acc = model_acc + 17'(rq.time_passed);
            while (model_acc >= TICKS_PER_HALF) begin
                model_acc = model_acc - TICKS_PER_HALF;
                half_step_count++;
                // carry half-second -> minute -> hour -> day
                if (model_cal.half_seconds < LAST_HALF_SECOND)
                    model_cal.half_seconds = model_cal.half_seconds + 7'd1;
                else begin
                    model_cal.half_seconds = '0;
                    if (model_cal.minutes < LAST_MINUTE)
                        model_cal.minutes = model_cal.minutes + 6'd1;
                    else begin
                        model_cal.minutes = '0;
                        if (model_cal.hours < LAST_HOUR)
                            model_cal.hours = model_cal.hours + 5'd1;
                        else begin
                            model_cal.hours = '0;
                            day_roll_count++;
                            model_cal.weekday = (model_cal.weekday >= LAST_WEEKDAY) ?
                                                3'd0 : model_cal.weekday + 3'd1;
                            if (model_cal.month == MONTH_FEB)
                                month_last = LAST_DATE_FEB;
                            else if (model_cal.month == MONTH_APR ||
                                     model_cal.month == MONTH_JUN ||
                                     model_cal.month == MONTH_SEP ||
                                     model_cal.month == MONTH_NOV)
                                month_last = LAST_DATE_SHORT;
                            else
                                month_last = LAST_DATE;
                            if (model_cal.date >= month_last) begin
                                model_cal.date = '0;
                                model_cal.month = (model_cal.month >= LAST_MONTH) ?
                                                  4'd0 : model_cal.month + 4'd1;
                            end
                            else
                                model_cal.date = model_cal.date + 5'd1;
                        end
                    end
                end
            end
        end
        else begin
            load_count++;
            model_cal.half_seconds = (rq.load_half_seconds > LAST_HALF_SECOND) ?
                                     LAST_HALF_SECOND : rq.load_half_seconds;
            model_cal.minutes = (rq.load_minutes > LAST_MINUTE) ? LAST_MINUTE : rq.load_minutes;
            model_cal.hours = (rq.load_hours > LAST_HOUR) ? LAST_HOUR : rq.load_hours;
            model_cal.weekday = (rq.load_weekday > LAST_WEEKDAY) ?
                                LAST_WEEKDAY : rq.load_weekday;
            model_cal.date = (rq.load_date > LAST_DATE) ? LAST_DATE : rq.load_date;
            model_cal.month = (rq.load_month > LAST_MONTH) ? LAST_MONTH : rq.load_month;
        end
        r.raw_ticks = model_total;
        r.sub_half_second = model_acc[13:0];
        r.half_seconds = model_cal.half_seconds;
        r.minutes = model_cal.minutes;
        r.hours = model_cal.hours;
        r.weekday = model_cal.weekday;
        r.date = model_cal.date;
        r.month = model_cal.month;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic request_t make_advance(input logic [15:0] ticks);
        request_t rq;
        rq = '1;
        rq.req_type = REQ_ADVANCE;
        rq.time_passed = ticks;
        return rq;
    endfunction

    function automatic request_t make_load(input logic [6:0] hs, input logic [5:0] mn,
                                           input logic [4:0] hr, input logic [2:0] wd,
                                           input logic [4:0] dt, input logic [3:0] mo);
        request_t rq;
        rq.req_type = REQ_LOAD;
        rq.time_passed = 16'($urandom);
        rq.load_half_seconds = hs;
        rq.load_minutes = mn;
        rq.load_hours = hr;
        rq.load_weekday = wd;
        rq.load_date = dt;
        rq.load_month = mo;
        return rq;
    endfunction

    // Queue one request; gaps vanish in every third stretch of 100 items.
    function automatic void queue_request(input request_t rq, input bit drain);
        pending_item_t it;
        it.req = rq;
        it.drain = drain;
        it.gap = (((pending_q.size() / 100) % 3) == 1) ? 0 : $urandom_range(0, 8);
        pending_q.push_back(it);
    endfunction

    // Request driver: predict on each transfer, then present the next pending item.
    pending_item_t cur_item;
    bit            have_item = 1'b0;
    int            gap_left = 0;

    always @(posedge clk or negedge rst_n) begin : drive_requests
        logic     nv;
        request_t nd;
        int       ng;
        if (!rst_n) begin
            req_valid <= 1'b0;
            req_data <= '0;
            gap_left <= 0;
        end
        else begin
            nv = req_valid;
            nd = req_data;
            ng = gap_left;
            if (request_ch.valid && request_ch.ready) begin
                clock_state_q.push_back(next_clock_state(request_ch.data));
                issued_count++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (!have_item && pending_q.size() > 0) begin
                    cur_item = pending_q.pop_front();
                    have_item = 1'b1;
                    ng = cur_item.gap;
                end
                if (have_item) begin
                    if (ng > 0)
                        ng--;
                    else if (!cur_item.drain || issued_count == results_seen) begin
                        nv = 1'b1;
                        nd = cur_item.req;
                        have_item = 1'b0;
                    end
                end
            end
            req_valid <= nv;
            req_data <= nd;
            gap_left <= ng;
        end
    end

    // Result monitor: compare each transfer with the oldest prediction, stall at random.
    int stall_left = 0;

    always @(posedge clk or negedge rst_n) begin : watch_results
        result_t want;
        int      ns;
        if (!rst_n) begin
            res_ready <= 1'b0;
            stall_left <= 0;
        end
        else begin
            ns = stall_left;
            if (status_ch.valid && status_ch.ready) begin
                if (clock_state_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual raw_ticks %0d",
                             $time, status_ch.data.raw_ticks);
                    mismatches++;
                end
                else begin
                    want = clock_state_q.pop_front();
                    check_field("raw_ticks", want.raw_ticks, status_ch.data.raw_ticks);
                    check_field("sub_half_second", want.sub_half_second,
                                status_ch.data.sub_half_second);
                    check_field("half_seconds", want.half_seconds, status_ch.data.half_seconds);
                    check_field("minutes", want.minutes, status_ch.data.minutes);
                    check_field("hours", want.hours, status_ch.data.hours);
                    check_field("weekday", want.weekday, status_ch.data.weekday);
                    check_field("date", want.date, status_ch.data.date);
                    check_field("month", want.month, status_ch.data.month);
                end
                results_seen <= results_seen + 1;
                ns = (((results_seen / 150) % 3) == 2) ? 0 : $urandom_range(0, 8);
            end
            else if (ns > 0)
                ns--;
            res_ready <= (ns == 0);
            stall_left <= ns;
        end
    end

    // Guard against a hang
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d of %0d results received", $time,
                     results_seen, issued_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : run_test
        request_t rq;
        int       pick;
        int       total_items;

        // zero and full-scale advances, up to five boundaries in one
        queue_request(make_advance(16'd0), 1'b0);
        queue_request(make_advance(16'd15999), 1'b0);
        queue_request(make_advance(16'hFFFF), 1'b0);
        queue_request(make_advance(16'd1), 1'b0);
        // out-of-range load saturates, then a year rollover
        queue_request(make_load(7'h7F, 6'h3F, 5'h1F, 3'h7, 5'h1F, 4'hF), 1'b0);
        queue_request(make_advance(16'd16000), 1'b0);
        queue_request(make_load(LAST_HALF_SECOND, LAST_MINUTE, LAST_HOUR, LAST_WEEKDAY,
                                LAST_DATE, LAST_MONTH), 1'b0);
        // date past the end of February
        queue_request(make_load(LAST_HALF_SECOND, LAST_MINUTE, LAST_HOUR, 3'd2,
                                LAST_DATE, MONTH_FEB), 1'b0);
        queue_request(make_advance(16'd16000), 1'b0);
        // regular last day of February
        queue_request(make_load(LAST_HALF_SECOND, LAST_MINUTE, LAST_HOUR, 3'd3,
                                LAST_DATE_FEB, MONTH_FEB), 1'b0);
        queue_request(make_advance(16'd16000), 1'b0);
        // end of a 30-day month
        queue_request(make_load(LAST_HALF_SECOND, LAST_MINUTE, LAST_HOUR, 3'd4,
                                LAST_DATE_SHORT, MONTH_APR), 1'b0);
        queue_request(make_advance(16'd16000), 1'b0);
        // end of January
        queue_request(make_load(LAST_HALF_SECOND, LAST_MINUTE, LAST_HOUR, 3'd5,
                                LAST_DATE, 4'd0), 1'b0);
        queue_request(make_advance(16'd16000), 1'b0);
        // date past the end of June
        queue_request(make_load(LAST_HALF_SECOND, LAST_MINUTE, LAST_HOUR, 3'd1,
                                LAST_DATE, MONTH_JUN), 1'b0);
        queue_request(make_advance(16'd16000), 1'b0);
        // minute and hour carry without a day change
        queue_request(make_load(LAST_HALF_SECOND, LAST_MINUTE, 5'd10, 3'd0, 5'd4, 4'd7), 1'b0);
        queue_request(make_advance(16'd32000), 1'b0);
        queue_request(make_load(7'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0), 1'b0);
        queue_request(make_advance(16'hFFFF), 1'b0);

        // random part: mostly advances, with loads near rollover points
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                rq = make_advance(16'($urandom));
            else if (pick < 55)
                rq = make_advance(16'(16000 * $urandom_range(1, 4) + $urandom_range(0, 2) - 1));
            else if (pick < 65)
                rq = make_advance(16'($urandom_range(0, 255)));
            else if (pick < 82)
                rq = make_load(7'($urandom_range(110, 127)), 6'($urandom_range(57, 63)),
                               5'($urandom_range(22, 31)), 3'($urandom),
                               5'($urandom_range(25, 31)), 4'($urandom));
            else begin
                rq = request_t'($bits(request_t)'({$urandom, $urandom}));
                rq.req_type = REQ_LOAD;
            end
            if (rq.req_type == REQ_ADVANCE) begin
                rq.load_half_seconds = 7'($urandom);
                rq.load_minutes = 6'($urandom);
                rq.load_hours = 5'($urandom);
                rq.load_weekday = 3'($urandom);
                rq.load_date = 5'($urandom);
                rq.load_month = 4'($urandom);
            end
            queue_request(rq, (i % 250) == 0);
        end
        total_items = pending_q.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (issued_count < total_items || results_seen != issued_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (clock_state_q.size() != 0) begin
            $display("%0t: %0d results expected but never received", $time,
                     clock_state_q.size());
            mismatches++;
        end
        $display("Ran %0d advances (%0d half-second steps, %0d day rollovers) and %0d loads,",
                 advance_count, half_step_count, day_roll_count, load_count);
        $display("checked %0d results field by field, %0d mismatches", results_seen,
                 mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
